FILE: rtl/tmrq_pkg.sv
// Package for the timer expiry queue: sizes, operation and status codes, beat types.
// Has no dependencies. Every module of the timer expiry queue imports it.
package tmrq_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int IDX_W      = $clog2(MAX_TIMERS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int TIME_W     = 48;
    localparam int WORD_W     = 32;

    localparam logic [1:0] KIND_REGISTER   = 2'd0;
    localparam logic [1:0] KIND_UNREGISTER = 2'd1;
    localparam logic [1:0] KIND_POLL       = 2'd2;

    localparam logic [2:0] ST_REGISTERED = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_REMOVED    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_FIRED      = 3'd4;
    localparam logic [2:0] ST_NOTHING    = 3'd5;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] now_time;
        logic [WORD_W-1:0] delay;
        logic [WORD_W-1:0] interval;
        logic [WORD_W-1:0] user_tag;
        logic [3:0]        slot_sel;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]        status;
        logic [3:0]        timer_id_res;
        logic [WORD_W-1:0] user_tag_res;
        logic              last;
    } t_out_beat;

endpackage

FILE: rtl/timer_expiry_queue_core.sv
// Timer expiry queue top level: slot valid flags, expiry and period/tag memories, control.
// Depends on tmrq_pkg.
//
// Usage: one input channel (i_in_valid, o_in_stall, i_in) carries register, unregister
// and poll beats; one output channel (o_out_valid, i_out_stall, o_out) returns results.
// The block handles one input beat at a time and stalls its input while busy.
// Register and unregister give one result each, written from the EXEC state once the output is free.
// A poll scans all slots through the expiry memory once per fired timer: each pass runs
// through SCAN, DRAIN and PICK, and a fire goes back to SCAN unless it was the last one;
// a poll with nothing due gives its single result after one pass.
// The scan is bound by the single read port of the expiry memory, one slot per cycle.
// Results leave through an output register; while the receiver stalls, the held beat
// stays put and the block waits before writing the next result, so the input side can
// take a new beat as soon as the last result of the previous one sits in that register.
// Reset frees every slot at once; the memories need no clearing pass and the block
// accepts beats in the first cycle after reset.
module timer_expiry_queue_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tmrq_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tmrq_pkg::t_out_beat o_out
);
    import tmrq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_FIRE
    } t_state;

    t_state                  r_state;
    t_in_beat                r_item;
    t_out_beat               r_out;
    logic                    r_out_valid;
    logic [MAX_TIMERS-1:0]   r_valid;
    logic [MAX_TIMERS-1:0]   r_fired;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_cmp_idx;
    logic                    r_cmp_act;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_found;
    logic [TIME_W-1:0]       r_best_exp;
    logic [IDX_W-1:0]        r_best_idx;

    logic [TIME_W-1:0]       exp_mem [MAX_TIMERS];
    logic [2*WORD_W-1:0]     pt_mem  [MAX_TIMERS];
    logic [TIME_W-1:0]       r_exp_rd;
    logic [2*WORD_W-1:0]     r_pt_rd;

    logic                    out_free;
    logic                    free_ok;
    logic [IDX_W-1:0]        free_idx;
    logic                    cand;
    logic                    better;
    logic                    fire_go;
    logic [WORD_W-1:0]       rd_period;
    logic [WORD_W-1:0]       rd_tag;
    logic                    exp_we;
    logic [IDX_W-1:0]        exp_wa;
    logic [TIME_W-1:0]       exp_wd;
    logic                    pt_we;

    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_ok  = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign out_free  = !r_out_valid || !i_out_stall;
    assign rd_period = r_pt_rd[2*WORD_W-1:WORD_W];
    assign rd_tag    = r_pt_rd[WORD_W-1:0];
    assign cand      = r_cmp_act && r_valid[r_cmp_idx] && !r_fired[r_cmp_idx]
                       && (r_exp_rd < r_item.now_time);
    assign better    = !r_found || (r_exp_rd < r_best_exp);
    assign fire_go   = (r_state == S_FIRE) && out_free;

    always_comb begin
        pt_we  = (r_state == S_EXEC) && (r_item.kind == KIND_REGISTER) && out_free && free_ok;
        exp_we = pt_we;
        exp_wa = free_idx;
        exp_wd = r_item.now_time + TIME_W'(r_item.delay);
        if (fire_go && (rd_period != '0)) begin
            exp_we = 1'b1;
            exp_wa = r_best_idx;
            exp_wd = r_item.now_time + TIME_W'(rd_period);
        end
    end

    always_ff @(posedge i_clk) begin
        if (exp_we) begin
            exp_mem[exp_wa] <= exp_wd;
        end
        if (pt_we) begin
            pt_mem[free_idx] <= {r_item.interval, r_item.user_tag};
        end
        r_exp_rd <= exp_mem[r_idx];
        r_pt_rd  <= pt_mem[r_best_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_fired     <= '0;
            r_idx       <= '0;
            r_cmp_act   <= 1'b0;
            r_cnt       <= '0;
            r_found     <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_cmp_act <= (r_state == S_SCAN);
            r_cmp_idx <= r_idx;
            if (cand) begin
                r_cnt <= r_cnt + 1'b1;
                if (better) begin
                    r_found    <= 1'b1;
                    r_best_exp <= r_exp_rd;
                    r_best_idx <= r_cmp_idx;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_item.kind)
                        KIND_REGISTER: begin
                            if (out_free) begin
                                r_out_valid        <= 1'b1;
                                r_out.user_tag_res <= '0;
                                r_out.last         <= 1'b1;
                                if (free_ok) begin
                                    r_valid[free_idx]  <= 1'b1;
                                    r_out.status       <= ST_REGISTERED;
                                    r_out.timer_id_res <= free_idx;
                                end else begin
                                    r_out.status       <= ST_FULL;
                                    r_out.timer_id_res <= '0;
                                end
                                r_state <= S_IDLE;
                            end
                        end
                        KIND_UNREGISTER: begin
                            if (out_free) begin
                                r_out_valid        <= 1'b1;
                                r_out.user_tag_res <= '0;
                                r_out.last         <= 1'b1;
                                r_out.timer_id_res <= r_item.slot_sel;
                                if (r_valid[r_item.slot_sel]) begin
                                    r_valid[r_item.slot_sel] <= 1'b0;
                                    r_out.status             <= ST_REMOVED;
                                end else begin
                                    r_out.status <= ST_NOT_FOUND;
                                end
                                r_state <= S_IDLE;
                            end
                        end
                        KIND_POLL: begin
                            r_fired <= '0;
                            r_idx   <= '0;
                            r_cnt   <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_W'(MAX_TIMERS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (r_cnt == '0) begin
                        if (out_free) begin
                            r_out_valid        <= 1'b1;
                            r_out.status       <= ST_NOTHING;
                            r_out.timer_id_res <= '0;
                            r_out.user_tag_res <= '0;
                            r_out.last         <= 1'b1;
                            r_state            <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_FIRE;
                    end
                end
                S_FIRE: begin
                    if (out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out.status         <= ST_FIRED;
                        r_out.timer_id_res   <= r_best_idx;
                        r_out.user_tag_res   <= rd_tag;
                        r_out.last           <= (r_cnt == CNT_W'(1));
                        r_fired[r_best_idx]  <= 1'b1;
                        if (rd_period == '0) begin
                            r_valid[r_best_idx] <= 1'b0;
                        end
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= '0;
                            r_cnt   <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_fire_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_go |-> !r_fired[r_best_idx])
        else $error("A timer was chosen to fire twice in one poll.");

    a_fire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_go |-> r_valid[r_best_idx])
        else $error("A free slot was chosen to fire.");

    a_none_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) && (r_cnt == '0) |-> (r_fired == '0))
        else $error("A scan found nothing due after a timer had fired in this poll.");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |-> (r_cnt <= CNT_W'($countones(r_valid & ~r_fired))))
        else $error("Due count exceeds the number of live unfired timers.");

    a_fire_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_go && (r_cnt != CNT_W'(1)) |=> (r_state == S_SCAN) && (r_idx == '0))
        else $error("A poll did not rescan after a fire that was not the last.");

endmodule
